### hw/rtl/sspq_pkg.sv
// Shared types and constants for the sorted-set priority queue.
package sspq_pkg;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_CONTAINS = 2'd2,
    MODE_POP_MIN  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_COMPARE,
    OP_INSERT,
    OP_DELETE,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### hw/rtl/sspq_cell.sv
// One slot of the sorted cell chain: key, valid bit and compare flags.
module sspq_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  sspq_pkg::cell_ctl_t               ctl,
  input  logic                              lt_prev,
  input  logic signed [sspq_pkg::KEY_W-1:0] below_key,
  input  logic                              below_valid,
  input  logic signed [sspq_pkg::KEY_W-1:0] above_key,
  input  logic                              above_valid,
  output logic signed [sspq_pkg::KEY_W-1:0] slot_key,
  output logic                              slot_valid,
  output logic                              lt,
  output logic                              eq
);
  import sspq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else begin
      case (ctl.op)
        OP_INSERT: begin
          if (!lt) begin
            slot_valid <= lt_prev ? 1'b1 : below_valid;
          end
        end
        OP_DELETE: begin
          if (!lt) begin
            slot_valid <= above_valid;
          end
        end
        OP_POP: begin
          slot_valid <= above_valid;
        end
        default: begin
          slot_valid <= slot_valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_COMPARE: begin
        lt <= slot_valid && (slot_key < ctl.key);
        eq <= slot_valid && (slot_key == ctl.key);
      end
      OP_INSERT: begin
        if (!lt) begin
          slot_key <= lt_prev ? ctl.key : below_key;
        end
      end
      OP_DELETE: begin
        if (!lt) begin
          slot_key <= above_key;
        end
      end
      OP_POP: begin
        slot_key <= above_key;
      end
      default: begin
        slot_key <= slot_key;
      end
    endcase
  end

endmodule

### hw/rtl/sorted_set_priority_queue_top.sv
// Sorted-set priority queue: a chain of compare-and-shift cells holding keys in order.
// The start transfer moves the control into the execute state; done is registered from that state.
// A new item is taken only while idle; compare in the accept cycle, reduce and shift next.
// Busy is high for the single execute cycle; results are not back-pressured.
// Reset empties the store (slot valid bits and occupancy cleared).
module sorted_set_priority_queue_top #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode,
  input  logic signed [sspq_pkg::KEY_W-1:0] key,
  output logic                              done,
  output logic                              success,
  output logic                              full_reject,
  output logic signed [sspq_pkg::KEY_W-1:0] popped_key,
  output logic [sspq_pkg::COUNT_W-1:0]      entry_count
);
  import sspq_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  state_t                  state;
  state_t                  state_next;
  mode_t                   mode_q;
  logic signed [KEY_W-1:0] key_q;
  logic [OCC_W-1:0]        occ;
  logic [OCC_W-1:0]        occ_next;
  logic [OCC_W+COUNT_W-1:0] occ_ext;
  cell_ctl_t               cell_ctl;
  logic                    accept;
  logic                    present;
  logic                    store_full;
  logic                    res_success;
  logic                    res_full;

  logic signed [KEY_W-1:0] key_arr   [CAPACITY];
  logic                    valid_vec [CAPACITY];
  logic [CAPACITY-1:0]     valid_bits;
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     eq_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    lt_prev;
    logic signed [KEY_W-1:0] below_key;
    logic                    below_valid;
    logic signed [KEY_W-1:0] above_key;
    logic                    above_valid;

    if (i == 0) begin : g_first
      assign lt_prev     = 1'b1;
      assign below_key   = '0;
      assign below_valid = 1'b0;
    end else begin : g_mid
      assign lt_prev     = lt_vec[i-1];
      assign below_key   = key_arr[i-1];
      assign below_valid = valid_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign above_key   = '0;
      assign above_valid = 1'b0;
    end else begin : g_inner
      assign above_key   = key_arr[i+1];
      assign above_valid = valid_vec[i+1];
    end

    sspq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .lt_prev     (lt_prev),
      .below_key   (below_key),
      .below_valid (below_valid),
      .above_key   (above_key),
      .above_valid (above_valid),
      .slot_key    (key_arr[i]),
      .slot_valid  (valid_vec[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );

    assign valid_bits[i] = valid_vec[i];
  end

  assign accept     = start && (state == ST_IDLE);
  assign present    = |eq_vec;
  assign store_full = (occ == OCC_W'(CAPACITY));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = (state == ST_EXEC);
    cell_ctl.op  = OP_HOLD;
    cell_ctl.key = key_q;
    res_success  = 1'b0;
    res_full     = 1'b0;
    occ_next     = occ;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cell_ctl.op  = OP_COMPARE;
          cell_ctl.key = key;
        end
      end
      ST_EXEC: begin
        case (mode_q)
          MODE_INSERT: begin
            if (!present && !store_full) begin
              cell_ctl.op = OP_INSERT;
              res_success = 1'b1;
              occ_next    = occ + OCC_W'(1);
            end
            res_full = !present && store_full;
          end
          MODE_REMOVE: begin
            if (present) begin
              cell_ctl.op = OP_DELETE;
              res_success = 1'b1;
              occ_next    = occ - OCC_W'(1);
            end
          end
          MODE_CONTAINS: begin
            res_success = present;
          end
          MODE_POP_MIN: begin
            if (occ != '0) begin
              cell_ctl.op = OP_POP;
              res_success = 1'b1;
              occ_next    = occ - OCC_W'(1);
            end
          end
          default: begin
            res_success = 1'b0;
          end
        endcase
      end
      default: begin
        cell_ctl.op = OP_HOLD;
      end
    endcase
  end

  assign occ_ext = {{COUNT_W{1'b0}}, occ_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= (state == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode_t'(mode);
      key_q  <= key;
    end
    if (state == ST_EXEC) begin
      success     <= res_success;
      full_reject <= res_full;
      popped_key  <= (mode_q == MODE_POP_MIN && res_success) ? key_arr[0] : '0;
      entry_count <= occ_ext[COUNT_W-1:0];
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without an execute cycle");

  a_single_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute phase held longer than one cycle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(success && full_reject))
    else $error("success and full_reject both set");

  a_valid_matches_occ: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ($countones(valid_bits) == int'(occ)))
    else $error("slot valid bits disagree with occupancy");

endmodule

### dv/sspq_checker.sv
// Checker for the sorted-set priority queue: tracks held keys, predicts and compares results.
`timescale 1ns / 100ps
module sspq_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        mode,
  input  logic signed [sspq_pkg::KEY_W-1:0] key,
  input  logic                              done,
  input  logic                              success,
  input  logic                              full_reject,
  input  logic signed [sspq_pkg::KEY_W-1:0] popped_key,
  input  logic [sspq_pkg::COUNT_W-1:0]      entry_count,
  output int                                failures,
  output int                                outstanding
);
  import sspq_pkg::*;

  typedef struct packed {
    logic                     success;
    logic                     full_reject;
    logic signed [KEY_W-1:0]  popped_key;
    logic [COUNT_W-1:0]       entry_count;
  } outcome_t;

  logic signed [KEY_W-1:0] held_keys[$];
  outcome_t                expected_outcomes[$];
  outcome_t                oldest;

  function automatic outcome_t next_outcome(input mode_t op, input logic signed [KEY_W-1:0] k);
    outcome_t res;
    int       slot;
    bit       present;
    res  = '0;
    slot = 0;
    while (slot < held_keys.size() && held_keys[slot] < k) slot++;
    present = slot < held_keys.size() && held_keys[slot] == k;
    case (op)
      MODE_INSERT: begin
        if (!present) begin
          if (held_keys.size() >= CAPACITY) begin
            res.full_reject = 1'b1;
          end else begin
            held_keys.insert(slot, k);
            res.success = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        if (present) begin
          held_keys.delete(slot);
          res.success = 1'b1;
        end
      end
      MODE_CONTAINS: begin
        res.success = present;
      end
      MODE_POP_MIN: begin
        if (held_keys.size() > 0) begin
          res.popped_key = held_keys.pop_front();
          res.success    = 1'b1;
        end
      end
      default: begin
        res.success = 1'b0;
      end
    endcase
    res.entry_count = COUNT_W'(held_keys.size());
    return res;
  endfunction

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      held_keys.delete();
      expected_outcomes.delete();
    end else begin
      if (done) begin
        if (expected_outcomes.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with no pending transfer: success=%0b full=%0b pop=%0d cnt=%0d",
                     $realtime, success, full_reject, popped_key, entry_count);
        end else begin
          oldest = expected_outcomes.pop_front();
          if (success !== oldest.success || full_reject !== oldest.full_reject ||
              popped_key !== oldest.popped_key || entry_count !== oldest.entry_count) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch exp success=%0b full=%0b pop=%0d cnt=%0d, got %0b %0b %0d %0d",
                       $realtime, oldest.success, oldest.full_reject, oldest.popped_key,
                       oldest.entry_count, success, full_reject, popped_key, entry_count);
          end
        end
      end
      if (start && !busy)
        expected_outcomes.push_back(next_outcome(mode_t'(mode), key));
    end
    outstanding = expected_outcomes.size();
  end

endmodule

### dv/tb_sorted_set_priority_queue_top.sv
// Testbench top for the sorted-set priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_sorted_set_priority_queue_top;
  import sspq_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic                     clk   = 1'b0;
  logic                     rst   = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               mode  = MODE_INSERT;
  logic signed [KEY_W-1:0]  key   = '0;
  logic                     busy;
  logic                     done;
  logic                     success;
  logic                     full_reject;
  logic signed [KEY_W-1:0]  popped_key;
  logic [COUNT_W-1:0]       entry_count;

  int                       failures;
  int                       outstanding;
  int                       cycle_count = 0;
  int                       sent        = 0;
  bit                       gaps_on     = 1'b1;
  logic signed [KEY_W-1:0]  recent_keys[16];

  always #2 clk = ~clk;

  sorted_set_priority_queue_top #(.CAPACITY(64)) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .key         (key),
    .done        (done),
    .success     (success),
    .full_reject (full_reject),
    .popped_key  (popped_key),
    .entry_count (entry_count)
  );

  sspq_checker #(.CAPACITY(64)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .key         (key),
    .done        (done),
    .success     (success),
    .full_reject (full_reject),
    .popped_key  (popped_key),
    .entry_count (entry_count),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sorted_set_priority_queue_top");
      $finish;
    end
  end

  task automatic send_item(input mode_t op, input logic signed [KEY_W-1:0] k);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode  <= op;
    key   <= k;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent++;
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key(input int wide_pct);
    int                      r;
    logic signed [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < wide_pct) begin
      k = {$urandom, $urandom};
      recent_keys[4'($urandom_range(0, 15))] = k;
    end else if (r < wide_pct + 5) begin
      case ($urandom_range(0, 3))
        0:       k = KEY_MIN;
        1:       k = KEY_MAX;
        2:       k = '1;
        default: k = '0;
      endcase
    end else if (r < wide_pct + 5 + (95 - wide_pct) / 2) begin
      k = recent_keys[4'($urandom_range(0, 15))];
    end else begin
      k = KEY_W'(int'($urandom_range(0, 40)) - 20);
    end
    return k;
  endfunction

  function automatic mode_t pick_mode(input int ins, input int rem, input int con);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins) return MODE_INSERT;
    if (r < ins + rem) return MODE_REMOVE;
    if (r < ins + rem + con) return MODE_CONTAINS;
    return MODE_POP_MIN;
  endfunction

  initial begin
    mode_t op;
    int    kind;
    int    span;
    int    wide;
    foreach (recent_keys[i]) recent_keys[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(MODE_POP_MIN,  64'sd77);
    send_item(MODE_CONTAINS, '0);
    send_item(MODE_REMOVE,   64'sd5);
    send_item(MODE_INSERT,   KEY_MIN);
    send_item(MODE_INSERT,   KEY_MAX);
    send_item(MODE_INSERT,   '0);
    send_item(MODE_INSERT,   '1);
    send_item(MODE_INSERT,   '0);
    send_item(MODE_CONTAINS, KEY_MAX);
    send_item(MODE_CONTAINS, 64'sd1);
    send_item(MODE_INSERT,   64'h5555_5555_5555_5555);
    send_item(MODE_INSERT,   64'hAAAA_AAAA_AAAA_AAAA);
    send_item(MODE_POP_MIN,  '0);
    send_item(MODE_REMOVE,   KEY_MAX);
    send_item(MODE_REMOVE,   KEY_MAX);
    send_item(MODE_CONTAINS, '1);
    send_item(MODE_POP_MIN,  '1);
    send_item(MODE_POP_MIN,  '0);
    send_item(MODE_POP_MIN,  '0);
    send_item(MODE_POP_MIN,  '0);
    send_item(MODE_POP_MIN,  KEY_MIN);

    while (sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 2);
      span = (kind == 0) ? $urandom_range(120, 200) : $urandom_range(60, 160);
      repeat (span) begin
        gaps_on = !(sent >= 700 && sent < 1000);
        case (kind)
          0: begin
            op   = pick_mode(75, 10, 10);
            wide = 70;
          end
          1: begin
            op   = pick_mode(15, 35, 15);
            wide = 20;
          end
          default: begin
            op   = pick_mode(30, 25, 25);
            wide = 40;
          end
        endcase
        send_item(op, pick_key(wide));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("PASS sorted_set_priority_queue_top");
    end else begin
      $display("FAIL sorted_set_priority_queue_top");
    end
    $finish;
  end

endmodule
